@@ src/set_pkg.sv @@
// ----------------------------------------------------------------------------
// set_pkg
// Shared types, constants and column arithmetic for the Sobel edge block.
// ----------------------------------------------------------------------------
package set_pkg;

	localparam int PIX_W      = 8;
	localparam int COL_OUT_W  = 8;
	localparam int ROW_W      = 12;
	localparam int DIM_W      = 13;
	localparam int WIDTH_W    = 9;
	localparam int THR_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int MIN_DIM    = 3;
	localparam int MAX_HEIGHT = 4096;
	localparam int WIDTH_RST  = 256;
	localparam int HEIGHT_RST = 256;
	localparam int THR_RST    = 35;
	localparam int LIM_W      = 17;
	localparam int SQ_W       = 14;
	localparam int MAG_W      = 15;

	localparam logic [PIX_W-1:0] EDGE_ON  = 8'hFF;
	localparam logic [PIX_W-1:0] EDGE_OFF = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH    = 2'd0,
		REG_IMAGE_HEIGHT   = 2'd1,
		REG_EDGE_THRESHOLD = 2'd2
	} cfg_reg_t;

	// one column of the 3x3 window
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} px_col_t;

	// vertical smoothing term used by the horizontal kernel
	function automatic logic [9:0] col_vsum(input px_col_t c);
		return {2'b00, c.top} + {1'b0, c.mid, 1'b0} + {2'b00, c.bot};
	endfunction

	// top minus bottom, used by the vertical kernel
	function automatic logic signed [8:0] col_vdiff(input px_col_t c);
		return $signed({1'b0, c.top}) - $signed({1'b0, c.bot});
	endfunction

	// divide by 8 truncating toward zero
	function automatic logic signed [7:0] div8_tz(input logic signed [10:0] x);
		logic signed [10:0] adj;
		adj = x + (x[10] ? 11'sd7 : 11'sd0);
		return 8'(adj >>> 3);
	endfunction

endpackage

@@ src/set_cfg_if.sv @@
// ----------------------------------------------------------------------------
// set_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface set_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [set_pkg::CFG_IDX_W-1:0]    index;
	logic [set_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ src/set_pixel_if.sv @@
// ----------------------------------------------------------------------------
// set_pixel_if
// Pixel request channel carrying one grey level in raster order.
// ----------------------------------------------------------------------------
interface set_pixel_if;
	logic                         valid;
	logic                         ready;
	logic [set_pkg::PIX_W-1:0]    pixel;

	modport source(output valid, pixel, input ready);
	modport sink(input valid, pixel, output ready);
endinterface

@@ src/set_result_if.sv @@
// ----------------------------------------------------------------------------
// set_result_if
// Result channel: edge flag and centre coordinates of one interior pixel.
// ----------------------------------------------------------------------------
interface set_result_if;
	logic                             valid;
	logic                             ready;
	logic [set_pkg::PIX_W-1:0]        edge_res;
	logic [set_pkg::COL_OUT_W-1:0]    center_col;
	logic [set_pkg::ROW_W-1:0]        center_row;

	modport source(output valid, edge_res, center_col, center_row, input ready);
	modport sink(input valid, edge_res, center_col, center_row, output ready);
endinterface

@@ src/set_ram.sv @@
// ----------------------------------------------------------------------------
// set_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module set_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/set_cell.sv @@
// ----------------------------------------------------------------------------
// set_cell
// One window column cell: holds a 3-pixel column and passes it on a shift.
// ----------------------------------------------------------------------------
module set_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift,
	input  set_pkg::px_col_t          feed,
	output set_pkg::px_col_t          held,
	output logic [9:0]                vsum,
	output logic signed [8:0]         vdiff
);

	set_pkg::px_col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= feed;
		end
	end

	assign held  = col_q;
	assign vsum  = set_pkg::col_vsum(col_q);
	assign vdiff = set_pkg::col_vdiff(col_q);

endmodule

@@ src/sobel_edge_threshold_top.sv @@
// A result passes stage 1, stage 2, stage 3 and the output register before it is valid on res.
// Throughput: one pixel per cycle while no stage holds; each stage holds only when the stage after it is full.
// Rate is set by the line-store read port, one read per pixel, and the window cell chain.
// Reset: counters, window cells and valid bits clear; registers return to 256/256/35.
// Line stores are not cleared; the first two rows and columns give no result.
// ----------------------------------------------------------------------------
// sobel_edge_threshold_top
// Streaming 3x3 Sobel edge detector with magnitude threshold.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_top #(
	parameter int MAX_WIDTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	set_cfg_if.sink             cfg,
	set_pixel_if.sink           px,
	set_result_if.source        res
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int DW = set_pkg::DIM_W;

	// configuration registers
	logic [set_pkg::WIDTH_W-1:0]  width_q;
	logic [DW-1:0]                height_q;
	logic [set_pkg::THR_W-1:0]    thr_q;
	logic [set_pkg::LIM_W-1:0]    lim_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= set_pkg::WIDTH_W'(set_pkg::WIDTH_RST);
			height_q <= DW'(set_pkg::HEIGHT_RST);
			thr_q    <= set_pkg::THR_W'(set_pkg::THR_RST);
		end else if (cfg.valid && cfg.ready) begin
			case (set_pkg::cfg_reg_t'(cfg.index))
				set_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg.data[set_pkg::WIDTH_W-1:0];
				end
				set_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg.data[DW-1:0];
				end
				set_pkg::REG_EDGE_THRESHOLD: begin
					thr_q <= cfg.data[set_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// squared threshold limit, (thr+1)^2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= set_pkg::LIM_W'((set_pkg::THR_RST + 1) * (set_pkg::THR_RST + 1));
		end else begin
			lim_q <= set_pkg::LIM_W'(9'(thr_q) + 9'd1) * set_pkg::LIM_W'(9'(thr_q) + 9'd1);
		end
	end

	// effective frame size
	logic [DW-1:0] w_raw, w_eff, h_eff;

	always_comb begin
		w_raw = DW'(width_q);
		if (w_raw < DW'(set_pkg::MIN_DIM)) begin
			w_eff = DW'(set_pkg::MIN_DIM);
		end else if (w_raw > DW'(MAX_WIDTH)) begin
			w_eff = DW'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		if (height_q < DW'(set_pkg::MIN_DIM)) begin
			h_eff = DW'(set_pkg::MIN_DIM);
		end else if (height_q > DW'(set_pkg::MAX_HEIGHT)) begin
			h_eff = DW'(set_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// raster position of the arriving pixel
	logic [CW-1:0]              col_q;
	logic [set_pkg::ROW_W-1:0]  row_q;
	logic [DW-1:0]              col_nxt, row_nxt, cc_full;
	logic                       wrap_col, wrap_row, has_res, acc;

	assign col_nxt  = DW'(col_q) + DW'(1);
	assign row_nxt  = DW'(row_q) + DW'(1);
	assign wrap_col = col_nxt >= w_eff;
	assign wrap_row = row_nxt >= h_eff;
	assign has_res  = (DW'(col_q) >= DW'(2)) && (DW'(row_q) >= DW'(2));
	assign cc_full  = DW'(col_q) - DW'(1);
	assign acc      = px.valid && px.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (wrap_col) begin
				col_q <= '0;
				row_q <= wrap_row ? '0 : row_nxt[set_pkg::ROW_W-1:0];
			end else begin
				col_q <= col_nxt[CW-1:0];
			end
		end
	end

	// stage handshake chain
	logic v1_q, res1_q, v2_q, v3_q, ov_q;
	logic go1, go2, go3, go4, leave1, adv1;

	assign go4    = !ov_q || res.ready;
	assign go3    = !v3_q || go4;
	assign go2    = !v2_q || go3;
	assign leave1 = !res1_q || go2;
	assign go1    = !v1_q || leave1;
	assign adv1   = v1_q && leave1;
	assign px.ready = go1;

	// stage 1: line store read data arrives
	logic [set_pkg::PIX_W-1:0]      pix_s1;
	logic [CW-1:0]                  addr_s1;
	logic [set_pkg::COL_OUT_W-1:0]  ccol_s1;
	logic [set_pkg::ROW_W-1:0]      crow_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			res1_q <= 1'b0;
		end else if (go1) begin
			v1_q   <= acc;
			res1_q <= acc && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= px.pixel;
			addr_s1 <= col_q;
			ccol_s1 <= cc_full[set_pkg::COL_OUT_W-1:0];
			crow_s1 <= row_q - set_pkg::ROW_W'(1);
		end
	end

	logic [set_pkg::PIX_W-1:0] rd_a, rd_b;

	// previous row
	set_ram #(.WIDTH(set_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_store_a (
		.clk   (clk),
		.we    (adv1),
		.waddr (addr_s1),
		.wdata (pix_s1),
		.re    (acc),
		.raddr (col_q),
		.rdata (rd_a)
	);

	// row before that
	set_ram #(.WIDTH(set_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_store_b (
		.clk   (clk),
		.we    (adv1),
		.waddr (addr_s1),
		.wdata (rd_a),
		.re    (acc),
		.raddr (col_q),
		.rdata (rd_b)
	);

	// window cells: cell 1 holds column c-1, cell 0 holds column c-2
	set_pkg::px_col_t  new_col, held1, held0;
	logic [9:0]        vs0, vs1, vs2;
	logic signed [8:0] vd0, vd1, vd2;

	assign new_col.top = rd_b;
	assign new_col.mid = rd_a;
	assign new_col.bot = pix_s1;
	assign vs2 = set_pkg::col_vsum(new_col);
	assign vd2 = set_pkg::col_vdiff(new_col);

	set_cell u_cell1 (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (adv1),
		.feed   (new_col),
		.held   (held1),
		.vsum   (vs1),
		.vdiff  (vd1)
	);

	set_cell u_cell0 (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (adv1),
		.feed   (held1),
		.held   (held0),
		.vsum   (vs0),
		.vdiff  (vd0)
	);

	// kernel sums; middle pixel of the centre column has zero weight
	logic signed [10:0] gx_full, gy_full;

	assign gx_full = $signed({1'b0, vs2}) - $signed({1'b0, vs0});
	assign gy_full = 11'(vd0) + (11'(vd1) <<< 1) + 11'(vd2);

	// stage 2: scaled gradients
	logic signed [7:0]              gx_s2, gy_s2;
	logic [set_pkg::COL_OUT_W-1:0]  ccol_s2;
	logic [set_pkg::ROW_W-1:0]      crow_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (go2) begin
			v2_q <= adv1 && res1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && res1_q) begin
			gx_s2   <= set_pkg::div8_tz(gx_full);
			gy_s2   <= set_pkg::div8_tz(gy_full);
			ccol_s2 <= ccol_s1;
			crow_s2 <= crow_s1;
		end
	end

	// stage 3: squares
	logic signed [15:0]             sqx, sqy;
	logic [set_pkg::SQ_W-1:0]       sqx_s3, sqy_s3;
	logic [set_pkg::COL_OUT_W-1:0]  ccol_s3;
	logic [set_pkg::ROW_W-1:0]      crow_s3;

	assign sqx = gx_s2 * gx_s2;
	assign sqy = gy_s2 * gy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
		end else if (go3) begin
			v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (v2_q && go3) begin
			sqx_s3  <= sqx[set_pkg::SQ_W-1:0];
			sqy_s3  <= sqy[set_pkg::SQ_W-1:0];
			ccol_s3 <= ccol_s2;
			crow_s3 <= crow_s2;
		end
	end

	// output register: magnitude compare
	logic [set_pkg::MAG_W-1:0]      mag;
	logic [set_pkg::PIX_W-1:0]      edge_q;
	logic [set_pkg::COL_OUT_W-1:0]  ccol_q;
	logic [set_pkg::ROW_W-1:0]      crow_q;

	assign mag = set_pkg::MAG_W'(sqx_s3) + set_pkg::MAG_W'(sqy_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (go4) begin
			ov_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (v3_q && go4) begin
			edge_q <= (set_pkg::LIM_W'(mag) >= lim_q) ? set_pkg::EDGE_ON
				: set_pkg::EDGE_OFF;
			ccol_q <= ccol_s3;
			crow_q <= crow_s3;
		end
	end

	assign res.valid      = ov_q;
	assign res.edge_res   = edge_q;
	assign res.center_col = ccol_q;
	assign res.center_row = crow_q;

	// line stores are only written as a pixel leaves stage 1
	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 |-> (v1_q && (!res1_q || go2)))
		else $error("line store written without a departing pixel");

	// an accepted interior pixel must occupy stage 1 as a result request
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && has_res) |=> (v1_q && res1_q))
		else $error("interior pixel lost at stage 1");

	// a result leaving the compare stage is either EDGE_ON or EDGE_OFF
	a_edge_code: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (edge_q == set_pkg::EDGE_ON || edge_q == set_pkg::EDGE_OFF))
		else $error("edge result outside its codes");

endmodule

@@ verif/sobel_edge_threshold_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel_edge_threshold_top_test
// Streams grey pixels through the Sobel edge block in bursts while the result
// side stalls. Each edge flag and its centre coordinates are predicted from a
// behavioural copy of the line stores, window and counters, then checked in order.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_top_test;

	localparam int MAX_W         = 256;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int LONG_HOLD     = 400;
	localparam int HOLD_AFTER    = 10;
	localparam int RANDOM_ITEMS  = 500;

	typedef enum {RX_FREE, RX_HALF, RX_SPARSE} rx_mode_t;

	typedef struct packed {
		logic [set_pkg::PIX_W-1:0]     edge_res;
		logic [set_pkg::COL_OUT_W-1:0] center_col;
		logic [set_pkg::ROW_W-1:0]     center_row;
	} edge_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	set_cfg_if    cfg();
	set_pixel_if  px();
	set_result_if res();

	sobel_edge_threshold_top #(.MAX_WIDTH(MAX_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.px(px),
		.res(res)
	);

	always #5 clk = ~clk;

	// behavioural copy of the block
	logic [set_pkg::WIDTH_W-1:0] width_reg = set_pkg::WIDTH_W'(set_pkg::WIDTH_RST);
	logic [set_pkg::DIM_W-1:0]   height_reg = set_pkg::DIM_W'(set_pkg::HEIGHT_RST);
	logic [set_pkg::THR_W-1:0]   thr_reg = set_pkg::THR_W'(set_pkg::THR_RST);
	logic [set_pkg::PIX_W-1:0]   row_above [MAX_W] = '{default: '0};
	logic [set_pkg::PIX_W-1:0]   row_above2 [MAX_W] = '{default: '0};
	logic [set_pkg::PIX_W-1:0]   win [6] = '{default: '0};
	int                          col_pos = 0;
	int                          row_pos = 0;

	edge_result_t                edges_due[$];
	logic [set_pkg::PIX_W-1:0]   pixel_queue[$];
	logic [set_pkg::PIX_W-1:0]   flat_level = '0;
	int                          px_pushed = 0;
	int                          px_accepted = 0;
	int                          results_seen = 0;
	int                          fail_count = 0;
	int                          quiet_cycles = 0;
	bit                          px_taken = 1'b0;

	int                          burst_left = 0;
	int                          gap_left = 0;
	int                          hold_left = 0;
	bit                          hold_done = 1'b0;
	int                          stall_left = 0;
	rx_mode_t                    stall_mode = RX_FREE;

	function automatic int used_width(input logic [set_pkg::WIDTH_W-1:0] v);
		if (v < set_pkg::MIN_DIM)
			return set_pkg::MIN_DIM;
		if (v > MAX_W)
			return MAX_W;
		return int'(v);
	endfunction

	function automatic int used_height(input logic [set_pkg::DIM_W-1:0] v);
		if (v < set_pkg::MIN_DIM)
			return set_pkg::MIN_DIM;
		if (v > set_pkg::MAX_HEIGHT)
			return set_pkg::MAX_HEIGHT;
		return int'(v);
	endfunction

	// wraps at or past the last column / row, so a shrunk size takes effect at once
	function automatic void advance_pos(inout int c, inout int r);
		if (c + 1 >= used_width(width_reg)) begin
			c = 0;
			r = (r + 1 >= used_height(height_reg)) ? 0 : r + 1;
		end else begin
			c = c + 1;
		end
	endfunction

	function automatic int steps_to_frame_start();
		int c;
		int r;
		int n;
		c = col_pos;
		r = row_pos;
		n = 0;
		do begin
			advance_pos(c, r);
			n++;
		end while (c != 0 || r != 0);
		return n;
	endfunction

	function automatic bit predict_edge(input logic [set_pkg::PIX_W-1:0] pix,
		output edge_result_t r);
		int t0, t1, t2, m0, m2, b0, b1, b2;
		int gx, gy, mag2, lim;
		bit hit;
		t0 = win[0];
		m0 = win[1];
		b0 = win[2];
		t1 = win[3];
		b1 = win[5];
		t2 = row_above2[col_pos];
		m2 = row_above[col_pos];
		b2 = pix;
		hit = (col_pos >= 2 && row_pos >= 2);
		r = '0;
		if (hit) begin
			// integer division truncates toward zero
			gx = ((t2 + 2 * m2 + b2) - (t0 + 2 * m0 + b0)) / 8;
			gy = ((t0 + 2 * t1 + t2) - (b0 + 2 * b1 + b2)) / 8;
			mag2 = gx * gx + gy * gy;
			lim = (int'(thr_reg) + 1) * (int'(thr_reg) + 1);
			r.edge_res = (mag2 >= lim) ? set_pkg::EDGE_ON : set_pkg::EDGE_OFF;
			r.center_col = set_pkg::COL_OUT_W'(col_pos - 1);
			r.center_row = set_pkg::ROW_W'(row_pos - 1);
		end
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = set_pkg::PIX_W'(t2);
		win[4] = set_pkg::PIX_W'(m2);
		win[5] = pix;
		row_above2[col_pos] = set_pkg::PIX_W'(m2);
		row_above[col_pos] = pix;
		advance_pos(col_pos, row_pos);
		return hit;
	endfunction

	function automatic logic [set_pkg::PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 1) != 0) ? set_pkg::EDGE_ON : set_pkg::EDGE_OFF;
			1, 2, 3: return flat_level + set_pkg::PIX_W'($urandom_range(0, 9));
			default: return set_pkg::PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic queue_pixel(input logic [set_pkg::PIX_W-1:0] p);
		pixel_queue.push_back(p);
		px_pushed++;
	endtask

	task automatic queue_random_pixels(input int n);
		repeat (n) begin
			if ($urandom_range(0, 31) == 0)
				flat_level = set_pkg::PIX_W'($urandom);
			queue_pixel(random_pixel());
		end
	endtask

	// 3x3 frame, first pixel in the top byte
	task automatic queue_frame(input logic [9*set_pkg::PIX_W-1:0] f);
		for (int i = 8; i >= 0; i--)
			queue_pixel(f[i*set_pkg::PIX_W +: set_pkg::PIX_W]);
	endtask

	task automatic write_reg(input set_pkg::cfg_reg_t idx,
		input logic [set_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
		@(posedge clk);
	endtask

	// all requests taken and all results in, then let the pipeline drain
	task automatic wait_idle();
		do @(negedge clk); while (px_accepted != px_pushed || edges_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// pixel driver: bursts of requests with gaps between them
	always @(negedge clk) begin
		logic send;
		send = 1'b0;
		if (!arst_n) begin
			px.valid = 1'b0;
		end else if (!px.valid || px_taken) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pixel_queue.size() > 0) begin
				send = 1'b1;
				px.pixel = pixel_queue.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
						: $urandom_range(0, 3);
				end
			end
			px.valid = send;
		end
	end

	// result side: stall segments, plus one long hold to back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			res.ready = 1'b0;
		end else if (hold_left > 0) begin
			res.ready = 1'b0;
			hold_left--;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			res.ready = 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 2));
				stall_left = $urandom_range(10, 80);
			end
			stall_left--;
			case (stall_mode)
				RX_FREE: res.ready = 1'b1;
				RX_HALF: res.ready = ($urandom_range(0, 1) != 0);
				default: res.ready = ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		edge_result_t want;
		edge_result_t got;
		edge_result_t fresh;
		px_taken = 1'b0;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (set_pkg::cfg_reg_t'(cfg.index))
					set_pkg::REG_IMAGE_WIDTH:
						width_reg = cfg.data[set_pkg::WIDTH_W-1:0];
					set_pkg::REG_IMAGE_HEIGHT:
						height_reg = cfg.data[set_pkg::DIM_W-1:0];
					set_pkg::REG_EDGE_THRESHOLD:
						thr_reg = cfg.data[set_pkg::THR_W-1:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				results_seen++;
				got = '{res.edge_res, res.center_col, res.center_row};
				if (edges_due.size() == 0) begin
					$error("unexpected result: edge_res %0d center_col %0d center_row %0d",
						got.edge_res, got.center_col, got.center_row);
					fail_count++;
				end else begin
					want = edges_due.pop_front();
					if (got.edge_res !== want.edge_res) begin
						$error("edge_res: expected %0d, got %0d", want.edge_res, got.edge_res);
						fail_count++;
					end
					if (got.center_col !== want.center_col) begin
						$error("center_col: expected %0d, got %0d",
							want.center_col, got.center_col);
						fail_count++;
					end
					if (got.center_row !== want.center_row) begin
						$error("center_row: expected %0d, got %0d",
							want.center_row, got.center_row);
						fail_count++;
					end
				end
			end
			px_taken = px.valid && px.ready;
			if (px_taken) begin
				px_accepted++;
				if (predict_edge(px.pixel, fresh))
					edges_due.push_back(fresh);
			end
		end
	end

	always @(posedge clk) begin
		if ((px.valid && px.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("sobel_edge_threshold_top_test: errors");
			$finish;
		end
	end

	initial begin
		logic [set_pkg::CFG_DATA_W-1:0] value;
		logic [set_pkg::THR_W-1:0]      thr;
		int                             n;
		int                             random_sent;
		bit                             first;
		bit                             at_start;
		cfg.valid = 1'b0;
		cfg.index = set_pkg::REG_IMAGE_WIDTH;
		cfg.data = '0;
		px.valid = 1'b0;
		px.pixel = '0;
		res.ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// full-scale step right, exactly on the threshold
		write_reg(set_pkg::REG_IMAGE_WIDTH, '0);
		write_reg(set_pkg::REG_IMAGE_HEIGHT, set_pkg::CFG_DATA_W'(2));
		write_reg(set_pkg::REG_EDGE_THRESHOLD, set_pkg::CFG_DATA_W'(126));
		queue_frame({8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF});
		wait_idle();
		// full-scale step left, just under the threshold
		write_reg(set_pkg::REG_EDGE_THRESHOLD, set_pkg::CFG_DATA_W'(127));
		queue_frame({8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00});
		wait_idle();
		// small negative sums must truncate to zero, not round down
		write_reg(set_pkg::REG_EDGE_THRESHOLD, '0);
		queue_frame({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h07});
		wait_idle();

		// narrowest image, forty rows; the long result hold falls inside this frame
		write_reg(set_pkg::REG_IMAGE_WIDTH, 13'h1E01);
		write_reg(set_pkg::REG_IMAGE_HEIGHT, set_pkg::CFG_DATA_W'(40));
		write_reg(set_pkg::REG_EDGE_THRESHOLD, 13'h1F14);
		queue_random_pixels(steps_to_frame_start());
		wait_idle();

		random_sent = 0;
		first = 1'b1;
		while (random_sent < RANDOM_ITEMS) begin
			at_start = (col_pos == 0 && row_pos == 0);
			if (first || $urandom_range(0, 1) != 0) begin
				case ($urandom_range(0, 3))
					0: value = set_pkg::CFG_DATA_W'($urandom_range(3, 16));
					1: value = set_pkg::CFG_DATA_W'($urandom_range(0, 2));
					2: value = {4'($urandom_range(1, 15)), 9'($urandom_range(3, 12))};
					default: value = set_pkg::CFG_DATA_W'($urandom_range(3, 6));
				endcase
				// widening mid-frame would read line store entries never written
				if (!at_start &&
					used_width(set_pkg::WIDTH_W'(value)) > used_width(width_reg))
					value = set_pkg::CFG_DATA_W'($urandom_range(0, used_width(width_reg)));
				write_reg(set_pkg::REG_IMAGE_WIDTH, value);
			end
			if (first || $urandom_range(0, 1) != 0) begin
				case ($urandom_range(0, 3))
					0: value = set_pkg::CFG_DATA_W'($urandom_range(0, 2));
					1: value = set_pkg::CFG_DATA_W'($urandom_range(13, 24));
					default: value = set_pkg::CFG_DATA_W'($urandom_range(3, 12));
				endcase
				write_reg(set_pkg::REG_IMAGE_HEIGHT, value);
			end
			if ($urandom_range(0, 1) != 0) begin
				case ($urandom_range(0, 5))
					0: thr = '0;
					1: thr = '1;
					2: thr = set_pkg::THR_W'($urandom_range(0, 255));
					default: thr = set_pkg::THR_W'($urandom_range(1, 60));
				endcase
				write_reg(set_pkg::REG_EDGE_THRESHOLD, {5'($urandom_range(0, 31)), thr});
			end
			first = 1'b0;
			// often finish on a frame boundary, otherwise stop mid-frame
			n = steps_to_frame_start();
			if (n > 400 || $urandom_range(0, 2) == 0)
				n = $urandom_range(1, 3 * used_width(width_reg) + 8);
			queue_random_pixels(n);
			random_sent += n;
			wait_idle();
		end

		if (fail_count == 0)
			$display("sobel_edge_threshold_top_test: clean");
		else
			$display("sobel_edge_threshold_top_test: errors");
		$finish;
	end

endmodule
